// ===== sv/mrip_pkg.sv =====
// Package for the multi-radix integer parser.
// Holds format and status codes, the item and result types, and digit/limit helpers.
// No dependencies.
package mrip_pkg;

  localparam logic [2:0] FMT_SDEC64 = 3'd0;
  localparam logic [2:0] FMT_UDEC64 = 3'd1;
  localparam logic [2:0] FMT_HEX64  = 3'd2;
  localparam logic [2:0] FMT_OCT64  = 3'd3;
  localparam logic [2:0] FMT_SDEC32 = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_byte;
    logic       last;
    logic       no_chars;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
  } result_t;

  function automatic logic fmt_signed(input logic [2:0] f);
    return (f == FMT_SDEC64) || (f == FMT_SDEC32);
  endfunction

  function automatic logic [4:0] fmt_max_digits(input logic [2:0] f);
    logic [4:0] m;
    case (f)
      FMT_SDEC64: m = 5'd19;
      FMT_UDEC64: m = 5'd20;
      FMT_HEX64:  m = 5'd16;
      FMT_OCT64:  m = 5'd22;
      FMT_SDEC32: m = 5'd10;
      default:    m = 5'd0;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] fmt_limit(input logic [2:0] f, input logic neg);
    logic [63:0] l;
    case (f)
      FMT_SDEC64: l = 64'h7fff_ffff_ffff_ffff + {63'd0, neg};
      FMT_SDEC32: l = 64'h0000_0000_7fff_ffff + {63'd0, neg};
      default:    l = 64'hffff_ffff_ffff_ffff;
    endcase
    return l;
  endfunction

  // {valid, digit} for character c in the radix of format f
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [2:0] f);
    logic       ok;
    logic [3:0] d;
    logic [4:0] r;
    ok = 1'b0;
    d  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      ok = 1'b1;
      d  = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      ok = 1'b1;
      d  = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      ok = 1'b1;
      d  = 4'(c - 8'h37);
    end
    case (f)
      FMT_HEX64: r = 5'd16;
      FMT_OCT64: r = 5'd8;
      default:   r = 5'd10;
    endcase
    if ({1'b0, d} >= r) ok = 1'b0;
    return {ok, d};
  endfunction

endpackage

// ===== sv/multi_radix_integer_parser_core.sv =====
// Top level of the multi-radix integer parser: input register, parse step, result register.
// Depends on mrip_pkg and mrip_step.
//
// Usage:
//   Slave channel carries one character per transfer. s_tdata is the character,
//   s_tuser selects the format (read on the first character of a string) and
//   flags an empty string, s_tlast marks the final character.
//   Master channel carries one result per string: m_tuser is the status
//   (ok, invalid, overflow), m_tdata the 64-bit value, zero on error.
//   Result path: a final character's result is formed from the input register
//   and loaded into the result register, which presents it on the master channel.
//   Throughput: one character per cycle unless a final character waits on a stalled
//   result; the per-character multiply by the radix and range compare are combinational.
//   Reset empties both registers and rearms the parser for a new string.
//   When the receiver stalls, the result register holds; the input register
//   still drains characters that give no result, and a final character waits
//   in the input register until the result register frees up.
module multi_radix_integer_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic [3:0]  s_tuser,   // [2:0] func, [3] no_chars
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] value
  output logic [1:0]  m_tuser    // [1:0] status
);
  import mrip_pkg::*;

  logic    in_v;
  item_t   in_item;
  logic    adv;
  logic    res_valid;
  result_t res;

  mrip_step u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  assign adv      = in_v && (!res_valid || !m_tvalid || m_tready);
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func      <= s_tuser[2:0];
      in_item.char_byte <= s_tdata;
      in_item.last      <= s_tlast;
      in_item.no_chars  <= s_tuser[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      m_tdata <= res.value;
      m_tuser <= res.status;
    end
  end

  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == 64'd0)
    else $error("nonzero value with error status");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_INVALID || m_tuser == ST_OVERFLOW)
    else $error("bad status code");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    in_v && !adv |=> in_v && $stable(in_item))
    else $error("input register lost a pending item");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(adv && res_valid))
    else $error("result overwritten while stalled");

endmodule

// ===== sv/mrip_step.sv =====
// Parse state and per-character update for the multi-radix integer parser.
// Holds accumulator, digit count, sign, first error and format; builds the result.
// Depends on mrip_pkg.
module mrip_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  mrip_pkg::item_t  item,
  output logic             res_valid,
  output mrip_pkg::result_t res
);
  import mrip_pkg::*;

  logic [63:0] acc, acc_next;
  logic [4:0]  cnt, cnt_next;
  logic        neg, neg_next;
  logic [1:0]  err, err_next;
  logic [2:0]  fmt, fmt_next;
  logic        at_start, at_start_next;

  logic [63:0] acc0;
  logic [4:0]  cnt0;
  logic [1:0]  err0;
  logic        neg0;
  logic [4:0]  dig;
  logic [67:0] prod;
  logic [68:0] sum;
  logic [63:0] lim;
  logic [4:0]  maxd;

  always_comb begin
    fmt_next = at_start ? item.func : fmt;
    acc0     = at_start ? 64'd0 : acc;
    cnt0     = at_start ? 5'd0 : cnt;
    neg0     = at_start ? 1'b0 : neg;
    err0     = at_start ? ST_OK : err;
    acc_next = acc0;
    cnt_next = cnt0;
    neg_next = neg0;
    err_next = err0;
    maxd     = fmt_max_digits(fmt_next);
    dig      = digit_of(item.char_byte, fmt_next);
    lim      = fmt_limit(fmt_next, neg0);
    case (fmt_next)
      FMT_HEX64: prod = {4'd0, acc0} << 4;
      FMT_OCT64: prod = {4'd0, acc0} << 3;
      default:   prod = ({4'd0, acc0} << 3) + ({4'd0, acc0} << 1);
    endcase
    sum = {1'b0, prod} + {65'd0, dig[3:0]};
    if (!item.no_chars) begin
      if (at_start && fmt_signed(fmt_next) &&
          (item.char_byte == CH_PLUS || item.char_byte == CH_MINUS)) begin
        neg_next = (item.char_byte == CH_MINUS);
      end else begin
        if (cnt0 < COUNT_MAX) cnt_next = cnt0 + 5'd1;
        if (err0 == ST_OK && fmt_next <= FMT_SDEC32 && cnt_next <= maxd) begin
          if (!dig[4]) begin
            err_next = ST_INVALID;
          end else if (sum > {5'd0, lim}) begin
            err_next = ST_OVERFLOW;
          end else begin
            acc_next = sum[63:0];
          end
        end
      end
    end
    res_valid     = item.last || item.no_chars;
    at_start_next = res_valid;
    res.value     = 64'd0;
    if (fmt_next > FMT_SDEC32 || cnt_next == 5'd0) begin
      res.status = ST_INVALID;
    end else if (cnt_next > maxd) begin
      res.status = ST_OVERFLOW;
    end else if (err_next != ST_OK) begin
      res.status = err_next;
    end else begin
      res.status = ST_OK;
      res.value  = neg_next ? (64'd0 - acc_next) : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= 64'd0;
      cnt      <= 5'd0;
      neg      <= 1'b0;
      err      <= ST_OK;
      fmt      <= FMT_SDEC64;
      at_start <= 1'b1;
    end else if (en) begin
      acc      <= acc_next;
      cnt      <= cnt_next;
      neg      <= neg_next;
      err      <= err_next;
      fmt      <= fmt_next;
      at_start <= at_start_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    en && res_valid |=> at_start)
    else $error("parser did not rearm after a result");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    err == ST_OK || err == ST_INVALID || err == ST_OVERFLOW)
    else $error("bad error code held");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    !at_start && fmt == FMT_SDEC32 |-> acc[63:32] == 32'd0)
    else $error("32-bit accumulator out of range");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for multi_radix_integer_parser_core: streams number texts one character per
// transfer, predicts status and value per string, and checks every result in order.
// Depends on mrip_pkg and the parser RTL.
module testbench;
  import mrip_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int TAIL_ITEMS   = 150;
  localparam int REPORT_MAX   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  always #4 clk = ~clk;

  multi_radix_integer_parser_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  item_t      pending_chars[$];
  result_t    expected_results[$];
  logic [7:0] text_q[$];
  item_t      cur_item;

  int    errors = 0;
  int    n_in = 0;
  int    n_out = 0;
  int    tail_from = 32'h7fffffff;
  int    src_gap = 0;
  int    snk_gap = 0;
  int    src_rate = 0;
  int    snk_rate = 0;
  int    hold_cycles = 0;
  bit    long_hold_done = 1'b0;
  longint cycles = 0;

  // parser state
  logic [63:0] acc_q = '0;
  logic [4:0]  count_q = '0;
  logic        neg_q = 1'b0;
  logic [1:0]  err_q = ST_OK;
  logic [2:0]  fmt_q = FMT_SDEC64;
  bit          fresh = 1'b1;

  function automatic int radix_of(logic [2:0] f);
    case (f)
      FMT_HEX64: return 16;
      FMT_OCT64: return 8;
      default:   return 10;
    endcase
  endfunction

  function automatic int digit_cap(logic [2:0] f);
    case (f)
      FMT_SDEC64: return 19;
      FMT_UDEC64: return 20;
      FMT_HEX64:  return 16;
      FMT_OCT64:  return 22;
      FMT_SDEC32: return 10;
      default:    return 0;
    endcase
  endfunction

  function automatic logic [63:0] magnitude_cap(logic [2:0] f, logic neg);
    case (f)
      FMT_SDEC64: return 64'h7fff_ffff_ffff_ffff + 64'(neg);
      FMT_SDEC32: return 64'h0000_0000_7fff_ffff + 64'(neg);
      default:    return 64'hffff_ffff_ffff_ffff;
    endcase
  endfunction

  function automatic int char_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] digit_char(int d, bit upper);
    if (d < 10) return 8'("0" + d);
    return upper ? 8'("A" + d - 10) : 8'("a" + d - 10);
  endfunction

  task automatic parse_char(item_t it);
    int      d;
    int      r;
    result_t res;
    if (fresh) begin
      acc_q   = '0;
      count_q = '0;
      neg_q   = 1'b0;
      err_q   = ST_OK;
      fmt_q   = it.func;
    end
    if (!it.no_chars) begin
      if (fresh && (fmt_q == FMT_SDEC64 || fmt_q == FMT_SDEC32) &&
          (it.char_byte == CH_PLUS || it.char_byte == CH_MINUS)) begin
        neg_q = (it.char_byte == CH_MINUS);
      end else begin
        if (count_q != COUNT_MAX) count_q++;
        if (err_q == ST_OK && fmt_q <= FMT_SDEC32 && count_q <= digit_cap(fmt_q)) begin
          r = radix_of(fmt_q);
          d = char_value(it.char_byte);
          if (d < 0 || d >= r) begin
            err_q = ST_INVALID;
          end else if (acc_q > (magnitude_cap(fmt_q, neg_q) - 64'(d)) / 64'(r)) begin
            err_q = ST_OVERFLOW;
          end else begin
            acc_q = acc_q * 64'(r) + 64'(d);
          end
        end
      end
    end
    fresh = 1'b0;
    if (it.last || it.no_chars) begin
      res.value = '0;
      if (fmt_q > FMT_SDEC32 || count_q == 0) begin
        res.status = ST_INVALID;
      end else if (count_q > digit_cap(fmt_q)) begin
        res.status = ST_OVERFLOW;
      end else if (err_q != ST_OK) begin
        res.status = err_q;
      end else begin
        res.status = ST_OK;
        res.value  = neg_q ? (64'd0 - acc_q) : acc_q;
      end
      expected_results.push_back(res);
      fresh = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < REPORT_MAX)
      $display("MISMATCH %s at result %0d: got %h expected %h", what, n_out, got, want);
    errors++;
  endtask

  // Turn the gathered text into transfers; drop_at >= 0 ends the string early by an
  // empty-flagged transfer at that position.
  task automatic emit_text(logic [2:0] f, int drop_at);
    item_t it;
    int    n;
    int    stop;
    n = text_q.size();
    if (drop_at > n) drop_at = n;
    stop = (drop_at < 0) ? n : drop_at;
    for (int i = 0; i < stop; i++) begin
      it.func      = (i == 0) ? f : 3'($urandom);
      it.char_byte = text_q[i];
      it.no_chars  = 1'b0;
      it.last      = (drop_at < 0 && i == n - 1);
      pending_chars.push_back(it);
    end
    if (drop_at >= 0 || n == 0) begin
      it.func      = (stop == 0) ? f : 3'($urandom);
      it.char_byte = 8'($urandom);
      it.no_chars  = 1'b1;
      it.last      = 1'($urandom);
      pending_chars.push_back(it);
    end
    text_q.delete();
  endtask

  task automatic emit_str(logic [2:0] f, string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    emit_text(f, -1);
  endtask

  // Append v in the given radix after whatever text is already gathered.
  task automatic add_digits(logic [71:0] v, int radix, bit upper);
    int base;
    base = text_q.size();
    do begin
      text_q.insert(base, digit_char(int'(v % 72'(radix)), upper));
      v = v / 72'(radix);
    end while (v != 0);
  endtask

  task automatic add_random_digits(int n, int radix);
    for (int i = 0; i < n; i++)
      text_q.push_back(digit_char($urandom_range(0, radix - 1), 1'($urandom)));
  endtask

  task automatic add_random_string();
    int          kind;
    int          n;
    bit          neg;
    logic [2:0]  f;
    logic [71:0] v;
    kind = $urandom_range(0, 99);
    f    = (kind >= 80 && kind < 92) ? 3'($urandom) : 3'($urandom_range(0, 4));
    neg  = 1'b0;
    if ((f == FMT_SDEC64 || f == FMT_SDEC32) && $urandom_range(0, 2) == 0) begin
      neg = 1'($urandom);
      text_q.push_back(neg ? CH_MINUS : CH_PLUS);
    end
    if (kind < 45) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, digit_cap(f)) : $urandom_range(1, 5);
      add_random_digits(n, radix_of(f));
      emit_text(f, ($urandom_range(0, 19) == 0) ? $urandom_range(0, n + 1) : -1);
    end else if (kind < 70) begin
      if ($urandom_range(0, 3) == 0) add_random_digits($urandom_range(1, 3), 1);
      v = 72'(magnitude_cap(f, neg)) - 72'd3 + 72'($urandom_range(0, 6));
      add_digits(v, radix_of(f), 1'($urandom));
      emit_text(f, -1);
    end else if (kind < 80) begin
      add_random_digits(digit_cap(f) + $urandom_range(1, 14), radix_of(f));
      if ($urandom_range(0, 1) == 1) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
      emit_text(f, -1);
    end else if (kind < 92) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        text_q.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'("0" + $urandom_range(0, 9)));
      emit_text(f, -1);
    end else begin
      add_random_digits($urandom_range(0, 4), radix_of(f));
      emit_text(f, $urandom_range(0, text_q.size()));
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    bit offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_char(cur_item);
        n_in++;
      end
      if ($urandom_range(0, 199) == 0) src_rate = $urandom_range(0, 2) * 6;
      if (!s_tvalid || s_tready) begin
        offer = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_chars.size() > 0) begin
          if (n_in < tail_from && src_rate != 0 && $urandom_range(1, src_rate) == 1) begin
            src_gap = $urandom_range(0, 8);
          end else begin
            cur_item = pending_chars.pop_front();
            offer = 1'b1;
          end
        end
        s_tvalid <= offer;
        if (offer) begin
          s_tdata <= cur_item.char_byte;
          s_tuser <= {cur_item.no_chars, cur_item.func};
          s_tlast <= cur_item.last;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : receive
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status) report_mismatch("status", 64'(m_tuser), 64'(want.status));
          if (m_tdata !== want.value) report_mismatch("value", m_tdata, want.value);
        end
        n_out++;
      end
      if ($urandom_range(0, 199) == 0) snk_rate = $urandom_range(0, 2) * 5;
      if (!long_hold_done && n_in >= 700) begin
        long_hold_done = 1'b1;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (n_in < tail_from && snk_rate != 0 && $urandom_range(1, snk_rate) == 1) begin
        snk_gap = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    emit_str(FMT_SDEC64, "");
    emit_str(FMT_SDEC64, "-");
    emit_str(FMT_SDEC32, "+7");
    emit_str(FMT_SDEC64, "-0");
    emit_str(FMT_HEX64, "aF");
    emit_str(FMT_OCT64, "9");
    emit_str(FMT_UDEC64, "+1");
    emit_str(FMT_SDEC64, "1-");
    emit_str(3'd7, "1");
    text_q.push_back(8'hff);
    emit_text(FMT_UDEC64, -1);
    text_q.push_back(8'h00);
    emit_text(FMT_HEX64, -1);
    emit_str(FMT_OCT64, "7");
    text_q.push_back("4");
    text_q.push_back("2");
    emit_text(FMT_SDEC64, 1);

    // hold off until every directed result is back
    do @(negedge clk);
    while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0);

    while (pending_chars.size() < RANDOM_ITEMS) add_random_string();
    tail_from = n_in + pending_chars.size() - TAIL_ITEMS;

    do @(negedge clk);
    while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
